/* hw/rtl/uvc_pkg.sv */
// ----------------------------------------------------------------------------
// uvc_pkg
// Shared types and constants for the UTF-8 validator and code point counter.
// ----------------------------------------------------------------------------
package uvc_pkg;

	localparam int COUNT_WIDTH = 24;
	localparam int OUT_COUNT_W = 24;
	localparam int CP_W        = 21;
	localparam int EXT_W       = 33;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;
	localparam logic [EXT_W-1:0]       OUT_MAX_EXT = EXT_W'(24'hFFFFFF);
	localparam logic [OUT_COUNT_W-1:0] OUT_MAX     = '1;

	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] SEQ2_LO   = 8'hC2;
	localparam logic [7:0] SEQ2_HI   = 8'hDF;
	localparam logic [7:0] SEQ3_LO   = 8'hE0;
	localparam logic [7:0] SEQ3_HI   = 8'hEF;
	localparam logic [7:0] SEQ4_LO   = 8'hF0;
	localparam logic [7:0] SEQ4_HI   = 8'hF4;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	localparam logic [CP_W-1:0] MIN_SEQ2  = 21'h80;
	localparam logic [CP_W-1:0] MIN_SEQ3  = 21'h800;
	localparam logic [CP_W-1:0] MIN_SEQ4  = 21'h10000;
	localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO   = 21'hD800;
	localparam logic [CP_W-1:0] SURR_HI   = 21'hDFFF;

	typedef enum logic [2:0] {
		LC_ASCII,
		LC_SEQ2,
		LC_SEQ3,
		LC_SEQ4,
		LC_BAD
	} lead_cls_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} uvc_in_t;

	typedef struct packed {
		logic [OUT_COUNT_W-1:0] codepoint_count;
		logic                   invalid;
	} uvc_out_t;

	typedef struct packed {
		lead_cls_t  lead_cls;
		logic [4:0] lead_bits;
		logic       is_cont;
		logic [5:0] cont_bits;
		logic       has_byte;
		logic       last;
	} uvc_cls_t;

endpackage

/* hw/rtl/uvc_front.sv */
// ----------------------------------------------------------------------------
// uvc_front
// Byte classifier: lead class, lead payload and continuation check per word.
// ----------------------------------------------------------------------------
module uvc_front import uvc_pkg::*; (
	input  uvc_in_t  in_word,
	output uvc_cls_t cls_word
);

	always_comb begin
		cls_word.has_byte  = in_word.has_byte;
		cls_word.last      = in_word.last;
		cls_word.is_cont   = (in_word.data_byte & CONT_MASK) == CONT_TAG;
		cls_word.cont_bits = in_word.data_byte[5:0];
		cls_word.lead_bits = 5'd0;
		if (in_word.data_byte <= ASCII_MAX) begin
			cls_word.lead_cls = LC_ASCII;
		end else if (in_word.data_byte >= SEQ2_LO && in_word.data_byte <= SEQ2_HI) begin
			cls_word.lead_cls  = LC_SEQ2;
			cls_word.lead_bits = in_word.data_byte[4:0];
		end else if (in_word.data_byte >= SEQ3_LO && in_word.data_byte <= SEQ3_HI) begin
			cls_word.lead_cls  = LC_SEQ3;
			cls_word.lead_bits = {1'b0, in_word.data_byte[3:0]};
		end else if (in_word.data_byte >= SEQ4_LO && in_word.data_byte <= SEQ4_HI) begin
			cls_word.lead_cls  = LC_SEQ4;
			cls_word.lead_bits = {2'b00, in_word.data_byte[2:0]};
		end else begin
			cls_word.lead_cls = LC_BAD;
		end
	end

endmodule

/* hw/rtl/uvc_queue.sv */
// ----------------------------------------------------------------------------
// uvc_queue
// Short register queue between the classifier and the decoder.
// ----------------------------------------------------------------------------
module uvc_queue import uvc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  uvc_cls_t    push_word,
	output logic        full,
	input  logic        pop,
	output logic        head_valid,
	output uvc_cls_t    head_word,
	output logic [QCNT_W-1:0] fill
);

	uvc_cls_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_word  = mem_q[rd_ptr_q];
	assign fill       = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

/* hw/rtl/uvc_back.sv */
// ----------------------------------------------------------------------------
// uvc_back
// Sequence decoder, code point counter and result register.
// ----------------------------------------------------------------------------
module uvc_back import uvc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  uvc_cls_t head_word,
	output logic     pop,
	output logic     pop_last,
	output logic     res_valid,
	input  logic     res_stall,
	output uvc_out_t res_word
);

	logic [COUNT_WIDTH-1:0] cnt_q, cnt_n;
	logic [1:0]             be_q, be_n;
	logic [2:0]             sw_q, sw_n;
	logic [CP_W-1:0]        pc_q, pc_n;
	logic                   err_q, err_n;
	logic                   bump;
	logic                   bad_cp;
	logic [CP_W-1:0]        cp;
	logic                   out_free;
	logic [EXT_W-1:0]       cnt_ext;
	uvc_out_t               fin;
	logic                   res_valid_q;
	uvc_out_t               res_word_q;

	assign out_free  = !res_valid_q || !res_stall;
	assign pop       = head_valid && (!head_word.last || out_free);
	assign pop_last  = pop && head_word.last;
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;
	assign cp        = {pc_q[CP_W-7:0], head_word.cont_bits};

	always_comb begin
		bad_cp = (sw_q == 3'd2 && cp < MIN_SEQ2) ||
			(sw_q == 3'd3 && cp < MIN_SEQ3) ||
			(sw_q == 3'd4 && cp < MIN_SEQ4) ||
			cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI);
		be_n  = be_q;
		sw_n  = sw_q;
		pc_n  = pc_q;
		err_n = err_q;
		bump  = 1'b0;
		if (head_word.has_byte && !err_q) begin
			if (be_q == 2'd0) begin
				unique case (head_word.lead_cls)
					LC_ASCII: bump = 1'b1;
					LC_SEQ2: begin
						sw_n = 3'd2;
						be_n = 2'd1;
						pc_n = CP_W'(head_word.lead_bits);
					end
					LC_SEQ3: begin
						sw_n = 3'd3;
						be_n = 2'd2;
						pc_n = CP_W'(head_word.lead_bits);
					end
					LC_SEQ4: begin
						sw_n = 3'd4;
						be_n = 2'd3;
						pc_n = CP_W'(head_word.lead_bits);
					end
					default: err_n = 1'b1;
				endcase
			end else if (!head_word.is_cont) begin
				err_n = 1'b1;
			end else begin
				be_n = be_q - 2'd1;
				pc_n = cp;
				if (be_q == 2'd1) begin
					if (bad_cp) begin
						err_n = 1'b1;
					end else begin
						bump = 1'b1;
					end
					sw_n = 3'd0;
					pc_n = '0;
				end
			end
		end
		cnt_n   = (bump && cnt_q != COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		cnt_ext = EXT_W'(cnt_n);
		fin.invalid = err_n || be_n != 2'd0;
		if (fin.invalid) begin
			fin.codepoint_count = '0;
		end else if (cnt_ext > OUT_MAX_EXT) begin
			fin.codepoint_count = OUT_MAX;
		end else begin
			fin.codepoint_count = cnt_ext[OUT_COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			be_q        <= '0;
			sw_q        <= '0;
			pc_q        <= '0;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head_word.last) begin
					cnt_q <= '0;
					be_q  <= '0;
					sw_q  <= '0;
					pc_q  <= '0;
					err_q <= 1'b0;
				end else begin
					cnt_q <= cnt_n;
					be_q  <= be_n;
					sw_q  <= sw_n;
					pc_q  <= pc_n;
					err_q <= err_n;
				end
			end
			if (out_free) begin
				res_valid_q <= pop_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_last) begin
			res_word_q <= fin;
		end
	end

endmodule

/* hw/rtl/utf8_validate_count_top.sv */
// ----------------------------------------------------------------------------
// utf8_validate_count_top
// Streaming UTF-8 validator and code point counter.
// ----------------------------------------------------------------------------
// Takes one byte word per cycle while byte_stall is low, with no gaps between
// buffers. A word marked last closes its buffer and yields one result word
// with the code point count (saturating, zero on error) and the invalid flag.
// The closing word passes through the four-entry register queue between the
// classifier and the decoder, then through the result register. The decoder
// updates its state once per byte, which sets the rate; the queue absorbs
// short result-side stalls before the byte side sees stall.
module utf8_validate_count_top import uvc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_stall,
	input  uvc_in_t  byte_word,
	output logic     result_valid,
	input  logic     result_stall,
	output uvc_out_t result_word
);

	uvc_cls_t          cls_word;
	uvc_cls_t          head_word;
	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              head_valid;
	logic              pop_last;
	logic [QCNT_W-1:0] q_fill;

	assign byte_stall = q_full;
	assign q_push     = byte_valid && !q_full;

	uvc_front u_front (
		.in_word  (byte_word),
		.cls_word (cls_word)
	);

	uvc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_word  (cls_word),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_word  (head_word),
		.fill       (q_fill)
	);

	uvc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_word  (head_word),
		.pop        (q_pop),
		.pop_last   (pop_last),
		.res_valid  (result_valid),
		.res_stall  (result_stall),
		.res_word   (result_word)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_fill <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill beyond depth");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(pop_last))
		else $error("result without a closing word");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.invalid |-> result_word.codepoint_count == '0)
		else $error("invalid result with nonzero count");

	a_hold_pop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> !pop_last)
		else $error("closing word taken while result stalled");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for utf8_validate_count_top
// Feeds byte buffers through the streaming UTF-8 validator with random gaps
// and result-side stalls, predicts each buffer's code point count and invalid
// flag, and compares every result word in order.
// ----------------------------------------------------------------------------
module testbench;
	import uvc_pkg::*;

	localparam int RANDOM_ITEMS = 1450;
	localparam int CYCLE_LIMIT  = 200000;

	typedef enum int {
		FR_RANDOM,
		FR_OPEN,
		FR_OVERLONG,
		FR_SURROGATE,
		FR_TOO_HIGH,
		FR_BAD_CONT
	} frag_kind_t;

	class utf8_scoreboard;
		logic [COUNT_WIDTH-1:0] cp_total;
		logic [1:0]             cont_left;
		logic [2:0]             seq_len;
		logic [CP_W-1:0]        cp_acc;
		logic                   bad_seen;
		uvc_out_t               want_q[$];
		int                     errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			cp_total  = '0;
			cont_left = '0;
			seq_len   = '0;
			cp_acc    = '0;
			bad_seen  = 1'b0;
		endfunction

		function void count_up();
			if (cp_total != COUNT_MAX)
				cp_total++;
		endfunction

		function lead_cls_t lead_class(logic [7:0] b);
			if (b <= ASCII_MAX)
				return LC_ASCII;
			if (b >= SEQ2_LO && b <= SEQ2_HI)
				return LC_SEQ2;
			if (b >= SEQ3_LO && b <= SEQ3_HI)
				return LC_SEQ3;
			if (b >= SEQ4_LO && b <= SEQ4_HI)
				return LC_SEQ4;
			return LC_BAD;
		endfunction

		function void note_word(uvc_in_t w);
			logic [CP_W-1:0]      cp;
			uvc_out_t             res;
			longint unsigned      cnt;
			if (w.has_byte && !bad_seen) begin
				if (cont_left == 0) begin
					case (lead_class(w.data_byte))
					LC_ASCII: count_up();
					LC_SEQ2: begin
						seq_len   = 3'd2;
						cp_acc    = CP_W'(w.data_byte[4:0]);
						cont_left = 2'd1;
					end
					LC_SEQ3: begin
						seq_len   = 3'd3;
						cp_acc    = CP_W'(w.data_byte[3:0]);
						cont_left = 2'd2;
					end
					LC_SEQ4: begin
						seq_len   = 3'd4;
						cp_acc    = CP_W'(w.data_byte[2:0]);
						cont_left = 2'd3;
					end
					default: bad_seen = 1'b1;
					endcase
				end else if ((w.data_byte & CONT_MASK) != CONT_TAG) begin
					bad_seen = 1'b1;
				end else begin
					cp = {cp_acc[CP_W-7:0], w.data_byte[5:0]};
					cont_left--;
					if (cont_left == 0) begin
						if ((seq_len == 3'd2 && cp < MIN_SEQ2) ||
								(seq_len == 3'd3 && cp < MIN_SEQ3) ||
								(seq_len == 3'd4 && cp < MIN_SEQ4) ||
								cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI))
							bad_seen = 1'b1;
						else
							count_up();
						seq_len = '0;
						cp_acc  = '0;
					end else begin
						cp_acc = cp;
					end
				end
			end
			if (w.last) begin
				res.invalid = bad_seen || cont_left != 0;
				cnt = res.invalid ? 0 : cp_total;
				if (cnt > OUT_MAX)
					cnt = OUT_MAX;
				res.codepoint_count = OUT_COUNT_W'(cnt);
				want_q.push_back(res);
				clear();
			end
		endfunction

		function void check_result(uvc_out_t r);
			uvc_out_t want;
			if (want_q.size() == 0) begin
				$display("%0t: unexpected result word: count %0d invalid %0b",
					$time, r.codepoint_count, r.invalid);
				errors++;
				return;
			end
			want = want_q.pop_front();
			if (r.codepoint_count !== want.codepoint_count) begin
				$display("%0t: codepoint_count mismatch: expected %0d actual %0d",
					$time, want.codepoint_count, r.codepoint_count);
				errors++;
			end
			if (r.invalid !== want.invalid) begin
				$display("%0t: invalid mismatch: expected %0b actual %0b",
					$time, want.invalid, r.invalid);
				errors++;
			end
		endfunction

		function int pending();
			return want_q.size();
		endfunction
	endclass

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     byte_valid   = 1'b0;
	logic     byte_stall;
	uvc_in_t  byte_word    = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	uvc_out_t result_word;

	utf8_scoreboard sb = new();
	logic [7:0]     text_bytes[$];
	bit             quiet_in  = 1'b0;
	bit             quiet_out = 1'b0;
	int             stall_left = 0;
	int             cycle_count = 0;

	utf8_validate_count_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_word    (byte_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** utf8_validate_count_top: FAILED **");
			$finish;
		end
	end

	// result side: random stall after each accepted word
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(result_word);
			if ($urandom_range(0, 7) == 0)
				quiet_out = !quiet_out;
			stall_left = quiet_out ? 0 : $urandom_range(0, 18);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		result_stall <= stall_left != 0;
	end

	task automatic send_word(input logic [7:0] d, input logic has, input logic fin);
		uvc_in_t w;
		int      gap;
		w.data_byte = d;
		w.has_byte  = has;
		w.last      = fin;
		gap = quiet_in ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_word  <= w;
		byte_valid <= 1'b1;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		sb.note_word(w);
	endtask

	function automatic logic [7:0] rand_cont();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic int unsigned random_codepoint();
		case (lead_cls_t'($urandom_range(0, 3)))
		LC_ASCII: return $urandom_range(0, 'h7F);
		LC_SEQ2: return $urandom_range('h80, 'h7FF);
		LC_SEQ3: return $urandom_range(0, 1) ? $urandom_range('h800, 'hD7FF)
			: $urandom_range('hE000, 'hFFFF);
		default: return $urandom_range('h10000, 'h10FFFF);
		endcase
	endfunction

	function automatic void add_codepoint(int unsigned cp);
		if (cp < 'h80) begin
			text_bytes.push_back(cp[7:0]);
		end else if (cp < 'h800) begin
			text_bytes.push_back({3'b110, cp[10:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end else if (cp < 'h10000) begin
			text_bytes.push_back({4'b1110, cp[15:12]});
			text_bytes.push_back({2'b10, cp[11:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end else begin
			text_bytes.push_back({5'b11110, cp[20:18]});
			text_bytes.push_back({2'b10, cp[17:12]});
			text_bytes.push_back({2'b10, cp[11:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end
	endfunction

	function automatic void add_fragment();
		case (frag_kind_t'($urandom_range(0, 5)))
		FR_RANDOM: text_bytes.push_back(8'($urandom_range(0, 255)));
		FR_OPEN: text_bytes.push_back(8'($urandom_range(SEQ2_LO, SEQ4_HI)));
		FR_OVERLONG: begin
			case ($urandom_range(0, 2))
			0: begin
				text_bytes.push_back(8'($urandom_range('hC0, 'hC1)));
				text_bytes.push_back(rand_cont());
			end
			1: begin
				text_bytes.push_back(SEQ3_LO);
				text_bytes.push_back(8'($urandom_range('h80, 'h9F)));
				text_bytes.push_back(rand_cont());
			end
			default: begin
				text_bytes.push_back(SEQ4_LO);
				text_bytes.push_back(8'($urandom_range('h80, 'h8F)));
				text_bytes.push_back(rand_cont());
				text_bytes.push_back(rand_cont());
			end
			endcase
		end
		FR_SURROGATE: begin
			text_bytes.push_back(8'hED);
			text_bytes.push_back(8'($urandom_range('hA0, 'hBF)));
			text_bytes.push_back(rand_cont());
		end
		FR_TOO_HIGH: begin
			if ($urandom_range(0, 1)) begin
				text_bytes.push_back(SEQ4_HI);
				text_bytes.push_back(8'($urandom_range('h90, 'hBF)));
				text_bytes.push_back(rand_cont());
				text_bytes.push_back(rand_cont());
			end else begin
				text_bytes.push_back(8'($urandom_range('hF5, 'hFF)));
			end
		end
		default: begin
			text_bytes.push_back(8'($urandom_range(SEQ2_LO, SEQ4_HI)));
			text_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 'h7F))
				: 8'($urandom_range('hC0, 'hFF)));
		end
		endcase
	endfunction

	initial begin
		int bytes_sent;
		int pieces;
		bit noisy;
		bit bare_end;
		bytes_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// valid extremes, an idle word and a bare end marker
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'h7F, 1'b1, 1'b0);
		send_word(8'hDF, 1'b1, 1'b0);
		send_word(8'hBF, 1'b1, 1'b0);
		send_word(8'h5A, 1'b0, 1'b0);
		send_word(8'hF4, 1'b1, 1'b0);
		send_word(8'h8F, 1'b1, 1'b0);
		send_word(8'hBF, 1'b1, 1'b0);
		send_word(8'hBF, 1'b1, 1'b0);
		send_word(8'hFF, 1'b0, 1'b1);
		// bad lead, then a byte after the error
		send_word(8'hC0, 1'b1, 1'b0);
		send_word(8'h41, 1'b1, 1'b1);
		// overlong three-byte form
		send_word(8'hE0, 1'b1, 1'b0);
		send_word(8'h80, 1'b1, 1'b0);
		send_word(8'h80, 1'b1, 1'b1);
		// surrogate
		send_word(8'hED, 1'b1, 1'b0);
		send_word(8'hA0, 1'b1, 1'b0);
		send_word(8'h80, 1'b1, 1'b1);
		// above the code point range
		send_word(8'hF4, 1'b1, 1'b0);
		send_word(8'h90, 1'b1, 1'b0);
		send_word(8'h80, 1'b1, 1'b0);
		send_word(8'h80, 1'b1, 1'b1);
		// end in mid-sequence, then an empty buffer
		send_word(8'hE0, 1'b1, 1'b1);
		send_word(8'h00, 1'b0, 1'b1);

		while (bytes_sent < RANDOM_ITEMS) begin
			text_bytes.delete();
			noisy  = $urandom_range(0, 3) == 0;
			pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
				: $urandom_range(0, 8);
			repeat (pieces)
				if (noisy && $urandom_range(0, 4) == 0)
					add_fragment();
				else
					add_codepoint(random_codepoint());
			if ($urandom_range(0, 5) == 0)
				quiet_in = !quiet_in;
			bare_end = text_bytes.size() == 0 || $urandom_range(0, 4) == 0;
			foreach (text_bytes[i]) begin
				if ($urandom_range(0, 15) == 0)
					send_word(8'($urandom), 1'b0, 1'b0);
				send_word(text_bytes[i], 1'b1, !bare_end && i == text_bytes.size() - 1);
			end
			if (bare_end)
				send_word(8'($urandom), 1'b0, 1'b1);
			bytes_sent += text_bytes.size() + int'(bare_end);
		end
		byte_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("** utf8_validate_count_top: PASSED **");
		else
			$display("** utf8_validate_count_top: FAILED **");
		$finish;
	end

endmodule
